/* hw/rtl/node_presence_supervisor_macros.svh */
// Assertion macros shared by the supervisor RTL.
`ifndef NODE_PRESENCE_SUPERVISOR_MACROS_SVH
`define NODE_PRESENCE_SUPERVISOR_MACROS_SVH

`ifndef SYNTHESIS

// Plain property, checked at every clock edge outside reset.
`define NPS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("nps assertion failed");

// Same-cycle implication.
`define NPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("nps implication failed");

`else

`define NPS_ASSERT(lbl, clk, rstn, prop)
`define NPS_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`endif

`endif

/* hw/rtl/nps_pkg.sv */
package nps_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned TICKS_W    = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_DEVICE_TYPE   = 2'd0,
    REG_OFFLINE_TIMEOUT   = 2'd1,
    REG_ANNOUNCE_RETRY    = 2'd2,
    REG_PERIODIC_INTERVAL = 2'd3
  } nps_reg_e;

  localparam logic [7:0]         RST_OWN_DEVICE_TYPE   = 8'd0;
  localparam logic [TICKS_W-1:0] RST_OFFLINE_TIMEOUT   = 20'd60000;
  localparam logic [TICKS_W-1:0] RST_ANNOUNCE_RETRY    = 20'd5000;
  localparam logic [TICKS_W-1:0] RST_PERIODIC_INTERVAL = 20'd10000;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_MESH_READY = 3'd1,
    CMD_MESH_RESET = 3'd2,
    CMD_HEARTBEAT  = 3'd3,
    CMD_ONLINE_ACK = 3'd4,
    CMD_SET_WARN   = 3'd5
  } nps_cmd_e;

  typedef enum logic [2:0] {
    LIGHT_UNPROVISIONED = 3'd0,
    LIGHT_ERROR         = 3'd1,
    LIGHT_WAIT_GATEWAY  = 3'd2,
    LIGHT_WARNING       = 3'd3,
    LIGHT_ONLINE        = 3'd4
  } nps_light_e;

  localparam int unsigned FLAG_PROVISIONED = 0;
  localparam int unsigned FLAG_REACHABLE   = 1;
  localparam int unsigned FLAG_ALERT       = 2;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] ack_device_type;
    logic [7:0] ack_token;
    logic       warning_value;
    logic       provisioned;
  } nps_in_t;

  typedef struct packed {
    logic       send_announce;
    logic [7:0] announce_token;
    logic       ack_accepted;
    logic       ack_first;
    logic       gateway_lost;
    logic       periodic_pulse;
    logic [2:0] light_mode;
    logic [2:0] state_flags;
  } nps_out_t;

  typedef struct packed {
    logic [7:0]         own_device_type;
    logic [TICKS_W-1:0] offline_timeout_ticks;
    logic [TICKS_W-1:0] announce_retry_ticks;
    logic [TICKS_W-1:0] periodic_interval_ticks;
  } nps_cfg_t;

endpackage

/* hw/rtl/nps_engine.sv */
module nps_engine #(
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  nps_pkg::nps_in_t  item_i,
  input  nps_pkg::nps_cfg_t cfg_i,
  output nps_pkg::nps_out_t result_o
);

  logic ready_q, ready_d;
  logic reach_q, reach_d;
  logic expired_q, expired_d;
  logic acked_q, acked_d;
  logic warn_q, warn_d;
  logic [7:0] token_q, token_d;
  logic [COUNT_WIDTH-1:0] wd_cnt_q, wd_cnt_d;
  logic [COUNT_WIDTH-1:0] rt_cnt_q, rt_cnt_d;
  logic [COUNT_WIDTH-1:0] pd_cnt_q, pd_cnt_d;
  logic wd_armed_q, wd_armed_d;
  logic rt_armed_q, rt_armed_d;
  logic pd_armed_q, pd_armed_d;

  // reloads: zero-extend or truncate to the counter width
  logic [COUNT_WIDTH+nps_pkg::TICKS_W-1:0] wd_ext, rt_ext, pd_ext;
  logic [COUNT_WIDTH-1:0] wd_reload, rt_reload, pd_reload;

  assign wd_ext    = {{COUNT_WIDTH{1'b0}}, cfg_i.offline_timeout_ticks};
  assign rt_ext    = {{COUNT_WIDTH{1'b0}}, cfg_i.announce_retry_ticks};
  assign pd_ext    = {{COUNT_WIDTH{1'b0}}, cfg_i.periodic_interval_ticks};
  assign wd_reload = wd_ext[COUNT_WIDTH-1:0];
  assign rt_reload = rt_ext[COUNT_WIDTH-1:0];
  assign pd_reload = pd_ext[COUNT_WIDTH-1:0];

  logic wd_fire, rt_fire, pd_fire;
  assign wd_fire = wd_armed_q && (wd_cnt_q <= COUNT_WIDTH'(1));
  assign rt_fire = rt_armed_q && (rt_cnt_q <= COUNT_WIDTH'(1));
  assign pd_fire = pd_armed_q && (pd_cnt_q <= COUNT_WIDTH'(1));

  logic ack_match;
  assign ack_match = ready_q && (item_i.ack_device_type == cfg_i.own_device_type)
                     && (item_i.ack_token == token_q);

  logic ann_do, ann_en;
  logic send, accepted, first, lost, pulse;

  always_comb begin
    ready_d    = ready_q;
    reach_d    = reach_q;
    expired_d  = expired_q;
    acked_d    = acked_q;
    warn_d     = warn_q;
    token_d    = token_q;
    wd_cnt_d   = wd_cnt_q;
    rt_cnt_d   = rt_cnt_q;
    pd_cnt_d   = pd_cnt_q;
    wd_armed_d = wd_armed_q;
    rt_armed_d = rt_armed_q;
    pd_armed_d = pd_armed_q;
    ann_do     = 1'b0;
    ann_en     = 1'b0;
    accepted   = 1'b0;
    first      = 1'b0;
    lost       = 1'b0;
    pulse      = 1'b0;

    case (item_i.command)
      nps_pkg::CMD_TICK: begin
        if (wd_armed_q && !wd_fire) wd_cnt_d = wd_cnt_q - COUNT_WIDTH'(1);
        if (rt_armed_q && !rt_fire) rt_cnt_d = rt_cnt_q - COUNT_WIDTH'(1);
        if (pd_armed_q && !pd_fire) pd_cnt_d = pd_cnt_q - COUNT_WIDTH'(1);
        if (wd_fire) begin
          wd_armed_d = 1'b0;
        end
        // a fresh gateway loss takes over the retry's announcement
        if (wd_fire && !expired_q) begin
          reach_d   = 1'b0;
          expired_d = 1'b1;
          acked_d   = 1'b0;
          token_d   = token_q + 8'd1;
          lost      = 1'b1;
          ann_do    = 1'b1;
          ann_en    = ready_q;
        end else if (rt_fire) begin
          ann_do = 1'b1;
          ann_en = ready_q && !acked_q;
        end
        if (pd_fire) begin
          pulse    = 1'b1;
          pd_cnt_d = pd_reload;
        end
      end
      nps_pkg::CMD_MESH_READY: begin
        ready_d    = 1'b1;
        reach_d    = 1'b0;
        expired_d  = 1'b0;
        acked_d    = 1'b0;
        token_d    = token_q + 8'd1;
        ann_do     = 1'b1;
        ann_en     = 1'b1;
        pulse      = 1'b1;
        pd_cnt_d   = pd_reload;
        pd_armed_d = 1'b1;
        wd_cnt_d   = wd_reload;
        wd_armed_d = 1'b1;
      end
      nps_pkg::CMD_MESH_RESET: begin
        ready_d    = 1'b0;
        reach_d    = 1'b0;
        expired_d  = 1'b0;
        acked_d    = 1'b0;
        warn_d     = 1'b0;
        wd_armed_d = 1'b0;
        rt_armed_d = 1'b0;
        pd_armed_d = 1'b0;
      end
      nps_pkg::CMD_HEARTBEAT: begin
        reach_d    = 1'b1;
        expired_d  = 1'b0;
        if (!reach_q && !acked_q) begin
          ann_do = 1'b1;
          ann_en = ready_q;
        end
        wd_cnt_d   = wd_reload;
        wd_armed_d = 1'b1;
      end
      nps_pkg::CMD_ONLINE_ACK: begin
        if (ack_match) begin
          accepted   = 1'b1;
          first      = !acked_q;
          acked_d    = 1'b1;
          reach_d    = 1'b1;
          expired_d  = 1'b0;
          rt_armed_d = 1'b0;
          wd_cnt_d   = wd_reload;
          wd_armed_d = 1'b1;
        end
      end
      nps_pkg::CMD_SET_WARN: begin
        warn_d = item_i.warning_value;
      end
      default: begin
      end
    endcase

    send = ann_do && ann_en;
    if (ann_do) begin
      rt_armed_d = ann_en;
      if (ann_en) rt_cnt_d = rt_reload;
    end
  end

  nps_pkg::nps_light_e light;
  always_comb begin
    if (!ready_d) begin
      light = nps_pkg::LIGHT_UNPROVISIONED;
    end else if (expired_d) begin
      light = nps_pkg::LIGHT_ERROR;
    end else if (!reach_d || !acked_d) begin
      light = nps_pkg::LIGHT_WAIT_GATEWAY;
    end else if (warn_d) begin
      light = nps_pkg::LIGHT_WARNING;
    end else begin
      light = nps_pkg::LIGHT_ONLINE;
    end
  end

  always_comb begin
    result_o.send_announce  = send;
    result_o.announce_token = token_d;
    result_o.ack_accepted   = accepted;
    result_o.ack_first      = first;
    result_o.gateway_lost   = lost;
    result_o.periodic_pulse = pulse;
    result_o.light_mode     = light;
    result_o.state_flags    = '0;
    result_o.state_flags[nps_pkg::FLAG_PROVISIONED] = item_i.provisioned;
    result_o.state_flags[nps_pkg::FLAG_REACHABLE]   = reach_d;
    result_o.state_flags[nps_pkg::FLAG_ALERT]       = warn_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q    <= 1'b0;
      reach_q    <= 1'b0;
      expired_q  <= 1'b0;
      acked_q    <= 1'b0;
      warn_q     <= 1'b0;
      token_q    <= 8'd0;
      wd_cnt_q   <= '0;
      rt_cnt_q   <= '0;
      pd_cnt_q   <= '0;
      wd_armed_q <= 1'b0;
      rt_armed_q <= 1'b0;
      pd_armed_q <= 1'b0;
    end else if (accept_i) begin
      ready_q    <= ready_d;
      reach_q    <= reach_d;
      expired_q  <= expired_d;
      acked_q    <= acked_d;
      warn_q     <= warn_d;
      token_q    <= token_d;
      wd_cnt_q   <= wd_cnt_d;
      rt_cnt_q   <= rt_cnt_d;
      pd_cnt_q   <= pd_cnt_d;
      wd_armed_q <= wd_armed_d;
      rt_armed_q <= rt_armed_d;
      pd_armed_q <= pd_armed_d;
    end
  end

endmodule

/* hw/rtl/node_presence_supervisor.sv */
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  nps_in_t   (one event)
// out       output     out_valid_o/out_stall_i nps_out_t (one status result)
// cfg       input      cfg_we_i               cfg_index_i, cfg_wdata_i
//
// One event per cycle while in_stall_o is low; its result reaches out_data_o the
// cycle after the transfer, later when earlier results are held by a stalled output.
// Engine flags, token and counters all update in the same cycle the event is taken.
// Output register plus one skid entry: input keeps flowing while a result is stalled;
// in_stall_o rises only once both entries hold results.
// Async active-low reset clears flags, counters (unarmed) and config to defaults.
`include "node_presence_supervisor_macros.svh"

module node_presence_supervisor #(
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  nps_pkg::nps_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output nps_pkg::nps_out_t                   out_data_o,
  input  logic                                cfg_we_i,
  input  logic [nps_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [nps_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  nps_pkg::nps_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_device_type         <= nps_pkg::RST_OWN_DEVICE_TYPE;
      cfg_q.offline_timeout_ticks   <= nps_pkg::RST_OFFLINE_TIMEOUT;
      cfg_q.announce_retry_ticks    <= nps_pkg::RST_ANNOUNCE_RETRY;
      cfg_q.periodic_interval_ticks <= nps_pkg::RST_PERIODIC_INTERVAL;
    end else if (cfg_we_i) begin
      case (nps_pkg::nps_reg_e'(cfg_index_i))
        nps_pkg::REG_OWN_DEVICE_TYPE:   cfg_q.own_device_type <= cfg_wdata_i[7:0];
        nps_pkg::REG_OFFLINE_TIMEOUT:   cfg_q.offline_timeout_ticks <= cfg_wdata_i;
        nps_pkg::REG_ANNOUNCE_RETRY:    cfg_q.announce_retry_ticks <= cfg_wdata_i;
        nps_pkg::REG_PERIODIC_INTERVAL: cfg_q.periodic_interval_ticks <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  logic in_xfer, out_xfer;
  logic out_valid_q, skid_valid_q;
  nps_pkg::nps_out_t out_q, skid_q, result;

  assign in_stall_o = skid_valid_q;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;

  nps_engine #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_xfer),
    .item_i   (in_data_i),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_xfer) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_xfer;
        end
      end else if (in_xfer) begin
        if (out_valid_q) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_xfer) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_xfer) begin
        out_q <= result;
      end
    end else if (in_xfer) begin
      if (out_valid_q) begin
        skid_q <= result;
      end else begin
        out_q <= result;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  logic chk_first, chk_online, chk_reach, chk_accepted;
  assign chk_first    = out_valid_o && out_data_o.ack_first;
  assign chk_online   = out_valid_o && (out_data_o.light_mode == nps_pkg::LIGHT_ONLINE);
  assign chk_reach    = out_data_o.state_flags[nps_pkg::FLAG_REACHABLE];
  assign chk_accepted = out_valid_o && out_data_o.ack_accepted;

  `NPS_ASSERT_IMP(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `NPS_ASSERT_IMP(a_first_needs_accept, clk_i, rst_ni, chk_first, out_data_o.ack_accepted)
  `NPS_ASSERT_IMP(a_online_reachable, clk_i, rst_ni, chk_online, chk_reach)
  `NPS_ASSERT_IMP(a_no_send_on_accept, clk_i, rst_ni, chk_accepted, !out_data_o.send_announce)

endmodule

/* dv/tb_node_presence_supervisor.sv */
module tb_node_presence_supervisor;
  timeunit 1ns;
  timeprecision 1ps;

  import nps_pkg::*;

  // unnamed command codes; the block must ignore them
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int unsigned IDLE_LIMIT = 2000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  nps_in_t               in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  nps_out_t              out_data_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // travels with in_data_i: a hand-written expectation for directed rows
  logic     typed_check = 1'b0;
  nps_out_t typed_status = '0;

  node_presence_supervisor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5ns clk_i = ~clk_i;

  // supervisor state mirror
  logic               p_ready = 1'b0, p_reach = 1'b0, p_expired = 1'b0;
  logic               p_acked = 1'b0, p_warn = 1'b0;
  logic [7:0]         p_token = '0;
  logic [TICKS_W-1:0] wd_cnt = '0, rt_cnt = '0, pd_cnt = '0;
  logic               wd_on = 1'b0, rt_on = 1'b0, pd_on = 1'b0;

  logic [7:0]         cfg_own = RST_OWN_DEVICE_TYPE;
  logic [TICKS_W-1:0] cfg_offline = RST_OFFLINE_TIMEOUT;
  logic [TICKS_W-1:0] cfg_retry = RST_ANNOUNCE_RETRY;
  logic [TICKS_W-1:0] cfg_period = RST_PERIODIC_INTERVAL;

  nps_out_t    status_q[$];
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_hold = 0;
  bit          quiet = 1'b0;

  typedef struct {
    bit                 is_write;
    nps_reg_e           reg_sel;
    logic [TICKS_W-1:0] reg_val;
    nps_in_t            ev;
    bit                 pinned;
    nps_out_t           want;
  } plan_row_t;

  plan_row_t plan_q[$];

  function automatic bit try_announce();
    if (p_ready && !p_acked) begin
      rt_cnt = cfg_retry;
      rt_on  = 1'b1;
      return 1'b1;
    end
    rt_on  = 1'b0;
    rt_cnt = '0;
    return 1'b0;
  endfunction

  function automatic nps_out_t next_status(input nps_in_t ev);
    nps_out_t r;
    bit wd_fire, rt_fire, pd_fire, was_reach;
    r = '0;
    case (ev.command)
      CMD_TICK: begin
        // a counter fires when it stood at 1 or 0 before the tick
        wd_fire = wd_on && (wd_cnt <= 1);
        rt_fire = rt_on && (rt_cnt <= 1);
        pd_fire = pd_on && (pd_cnt <= 1);
        if (wd_on) wd_cnt = wd_fire ? '0 : wd_cnt - 1'b1;
        if (rt_on) rt_cnt = rt_fire ? '0 : rt_cnt - 1'b1;
        if (pd_on) pd_cnt = pd_fire ? '0 : pd_cnt - 1'b1;
        if (wd_fire) begin
          wd_on = 1'b0;
          if (!p_expired) begin
            p_reach   = 1'b0;
            p_expired = 1'b1;
            p_acked   = 1'b0;
            p_token   = p_token + 8'd1;
            r.gateway_lost  = 1'b1;
            r.send_announce = try_announce();
            rt_fire = 1'b0;
          end
        end
        if (rt_fire) r.send_announce = try_announce();
        if (pd_fire) begin
          r.periodic_pulse = 1'b1;
          pd_cnt = cfg_period;
        end
      end
      CMD_MESH_READY: begin
        p_ready   = 1'b1;
        p_reach   = 1'b0;
        p_expired = 1'b0;
        p_acked   = 1'b0;
        p_token   = p_token + 8'd1;
        r.send_announce  = try_announce();
        r.periodic_pulse = 1'b1;
        pd_cnt = cfg_period;
        pd_on  = 1'b1;
        wd_cnt = cfg_offline;
        wd_on  = 1'b1;
      end
      CMD_MESH_RESET: begin
        p_ready   = 1'b0;
        p_reach   = 1'b0;
        p_expired = 1'b0;
        p_acked   = 1'b0;
        p_warn    = 1'b0;
        wd_on = 1'b0;
        rt_on = 1'b0;
        pd_on = 1'b0;
        wd_cnt = '0;
        rt_cnt = '0;
        pd_cnt = '0;
      end
      CMD_HEARTBEAT: begin
        was_reach = p_reach;
        p_reach   = 1'b1;
        p_expired = 1'b0;
        if (!was_reach && !p_acked) r.send_announce = try_announce();
        wd_cnt = cfg_offline;
        wd_on  = 1'b1;
      end
      CMD_ONLINE_ACK: begin
        if (p_ready && ev.ack_device_type == cfg_own && ev.ack_token == p_token) begin
          r.ack_accepted = 1'b1;
          r.ack_first    = !p_acked;
          p_acked   = 1'b1;
          p_reach   = 1'b1;
          p_expired = 1'b0;
          rt_on  = 1'b0;
          rt_cnt = '0;
          wd_cnt = cfg_offline;
          wd_on  = 1'b1;
        end
      end
      CMD_SET_WARN: begin
        p_warn = ev.warning_value;
      end
      default: begin
      end
    endcase
    r.announce_token = p_token;
    if (!p_ready) r.light_mode = LIGHT_UNPROVISIONED;
    else if (p_expired) r.light_mode = LIGHT_ERROR;
    else if (!p_reach || !p_acked) r.light_mode = LIGHT_WAIT_GATEWAY;
    else if (p_warn) r.light_mode = LIGHT_WARNING;
    else r.light_mode = LIGHT_ONLINE;
    r.state_flags[FLAG_PROVISIONED] = ev.provisioned;
    r.state_flags[FLAG_REACHABLE]   = p_reach;
    r.state_flags[FLAG_ALERT]       = p_warn;
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $time, result_count, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic compare_status(input nps_out_t got, input nps_out_t want);
    check_field("send_announce", 8'(got.send_announce), 8'(want.send_announce));
    check_field("announce_token", got.announce_token, want.announce_token);
    check_field("ack_accepted", 8'(got.ack_accepted), 8'(want.ack_accepted));
    check_field("ack_first", 8'(got.ack_first), 8'(want.ack_first));
    check_field("gateway_lost", 8'(got.gateway_lost), 8'(want.gateway_lost));
    check_field("periodic_pulse", 8'(got.periodic_pulse), 8'(want.periodic_pulse));
    check_field("light_mode", 8'(got.light_mode), 8'(want.light_mode));
    check_field("state_flags", 8'(got.state_flags), 8'(want.state_flags));
  endtask

  // Compare first, then push: a result never belongs to the input taken on the same edge.
  always @(posedge clk_i) begin
    nps_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (status_q.size() == 0) note_mismatch("result with nothing expected");
        else compare_status(out_data_o, status_q.pop_front());
        result_count++;
      end
      if (in_valid_i && !in_stall_o) begin
        want = next_status(in_data_i);
        if (typed_check) want = typed_status;
        status_q.push_back(want);
      end
    end
  end

  // result side: stall for a random count after each transfer
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) rx_hold = quiet ? 0 : $urandom_range(0, 7);
    if (rx_hold != 0) begin
      out_stall_i <= 1'b1;
      rx_hold--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_event(input nps_in_t ev, input bit pinned, input nps_out_t want);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_data_i    <= ev;
    typed_check  <= pinned;
    typed_status <= want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (status_q.size() != 0);
  endtask

  task automatic write_reg(input nps_reg_e sel, input logic [TICKS_W-1:0] val);
    case (sel)
      REG_OWN_DEVICE_TYPE:   cfg_own = val[7:0];
      REG_OFFLINE_TIMEOUT:   cfg_offline = val;
      REG_ANNOUNCE_RETRY:    cfg_retry = val;
      REG_PERIODIC_INTERVAL: cfg_period = val;
      default: ;
    endcase
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sel;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_regs(input logic [7:0] own, input logic [TICKS_W-1:0] offline,
                           input logic [TICKS_W-1:0] retry, input logic [TICKS_W-1:0] period);
    settle();
    write_reg(REG_OWN_DEVICE_TYPE, {12'd0, own});
    write_reg(REG_OFFLINE_TIMEOUT, offline);
    write_reg(REG_ANNOUNCE_RETRY, retry);
    write_reg(REG_PERIODIC_INTERVAL, period);
  endtask

  function automatic nps_in_t ev_of(input logic [2:0] cmd, input logic [7:0] dtype,
                                    input logic [7:0] tok, input logic warn, input logic prov);
    nps_in_t ev;
    ev.command         = cmd;
    ev.ack_device_type = dtype;
    ev.ack_token       = tok;
    ev.warning_value   = warn;
    ev.provisioned     = prov;
    return ev;
  endfunction

  function automatic nps_out_t status_of(input logic send, input logic [7:0] tok,
                                         input logic acc, input logic first, input logic lost,
                                         input logic pulse, input nps_light_e light,
                                         input logic [2:0] flags);
    nps_out_t r;
    r.send_announce  = send;
    r.announce_token = tok;
    r.ack_accepted   = acc;
    r.ack_first      = first;
    r.gateway_lost   = lost;
    r.periodic_pulse = pulse;
    r.light_mode     = light;
    r.state_flags    = flags;
    return r;
  endfunction

  function automatic void add_pinned(input nps_in_t ev, input nps_out_t want);
    plan_row_t row;
    row = '{is_write: 1'b0, reg_sel: REG_OWN_DEVICE_TYPE, reg_val: '0,
            ev: ev, pinned: 1'b1, want: want};
    plan_q.push_back(row);
  endfunction

  function automatic void add_event(input nps_in_t ev);
    plan_row_t row;
    row = '{is_write: 1'b0, reg_sel: REG_OWN_DEVICE_TYPE, reg_val: '0,
            ev: ev, pinned: 1'b0, want: '0};
    plan_q.push_back(row);
  endfunction

  function automatic void add_write(input nps_reg_e sel, input logic [TICKS_W-1:0] val);
    plan_row_t row;
    row = '{is_write: 1'b1, reg_sel: sel, reg_val: val, ev: '0, pinned: 1'b0, want: '0};
    plan_q.push_back(row);
  endfunction

  // Mostly well-formed traffic: ticks, heartbeats and acks aimed at the live or next token.
  function automatic nps_in_t random_event();
    nps_in_t ev;
    int unsigned pick;
    ev.ack_device_type = 8'($urandom_range(0, 255));
    ev.ack_token       = 8'($urandom_range(0, 255));
    ev.warning_value   = 1'($urandom_range(0, 1));
    ev.provisioned     = ($urandom_range(0, 9) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      ev.command = CMD_TICK;
    end else if (pick < 58) begin
      ev.command = CMD_HEARTBEAT;
    end else if (pick < 74) begin
      ev.command = CMD_ONLINE_ACK;
      if ($urandom_range(0, 4) != 0) ev.ack_device_type = cfg_own;
      pick = $urandom_range(0, 9);
      // the mirror may lag by one event, so aim at the next token as well
      if (pick < 5) ev.ack_token = p_token;
      else if (pick < 8) ev.ack_token = p_token + 8'd1;
    end else if (pick < 81) begin
      ev.command = CMD_MESH_READY;
    end else if (pick < 84) begin
      ev.command = CMD_MESH_RESET;
    end else if (pick < 94) begin
      ev.command = CMD_SET_WARN;
    end else if (pick < 97) begin
      ev.command = CMD_SPARE_LO;
    end else begin
      ev.command = CMD_SPARE_HI;
    end
    return ev;
  endfunction

  initial begin
    int unsigned phase;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults after reset: own type 0, long timeouts
    add_pinned(ev_of(CMD_TICK, 8'h00, 8'h00, 1'b0, 1'b1),
               status_of(1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, LIGHT_UNPROVISIONED, 3'b001));
    add_pinned(ev_of(CMD_SPARE_HI, 8'hFF, 8'hFF, 1'b1, 1'b0),
               status_of(1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, LIGHT_UNPROVISIONED, 3'b000));
    add_pinned(ev_of(CMD_SET_WARN, 8'h00, 8'h00, 1'b1, 1'b1),
               status_of(1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, LIGHT_UNPROVISIONED, 3'b101));
    add_pinned(ev_of(CMD_MESH_READY, 8'h00, 8'h00, 1'b0, 1'b1),
               status_of(1'b1, 8'd1, 1'b0, 1'b0, 1'b0, 1'b1, LIGHT_WAIT_GATEWAY, 3'b101));
    add_pinned(ev_of(CMD_ONLINE_ACK, 8'hFF, 8'h01, 1'b0, 1'b1),
               status_of(1'b0, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0, LIGHT_WAIT_GATEWAY, 3'b101));
    add_pinned(ev_of(CMD_ONLINE_ACK, 8'h00, 8'h00, 1'b0, 1'b1),
               status_of(1'b0, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0, LIGHT_WAIT_GATEWAY, 3'b101));
    add_pinned(ev_of(CMD_ONLINE_ACK, 8'h00, 8'h01, 1'b0, 1'b1),
               status_of(1'b0, 8'd1, 1'b1, 1'b1, 1'b0, 1'b0, LIGHT_WARNING, 3'b111));
    add_pinned(ev_of(CMD_ONLINE_ACK, 8'h00, 8'h01, 1'b0, 1'b1),
               status_of(1'b0, 8'd1, 1'b1, 1'b0, 1'b0, 1'b0, LIGHT_WARNING, 3'b111));
    add_pinned(ev_of(CMD_SET_WARN, 8'h00, 8'h00, 1'b0, 1'b1),
               status_of(1'b0, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0, LIGHT_ONLINE, 3'b011));
    add_pinned(ev_of(CMD_MESH_RESET, 8'h00, 8'h00, 1'b0, 1'b0),
               status_of(1'b0, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0, LIGHT_UNPROVISIONED, 3'b000));
    // ack on a node that is not ready is ignored
    add_pinned(ev_of(CMD_ONLINE_ACK, 8'h00, 8'h01, 1'b0, 1'b1),
               status_of(1'b0, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0, LIGHT_UNPROVISIONED, 3'b001));
    add_pinned(ev_of(CMD_HEARTBEAT, 8'h00, 8'h00, 1'b0, 1'b1),
               status_of(1'b0, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0, LIGHT_UNPROVISIONED, 3'b011));
    // short reloads: retry, periodic and watchdog expiry within a few ticks
    add_write(REG_OWN_DEVICE_TYPE, 20'hFF);
    add_write(REG_OFFLINE_TIMEOUT, 20'd3);
    add_write(REG_ANNOUNCE_RETRY, 20'd2);
    add_write(REG_PERIODIC_INTERVAL, 20'd2);
    add_event(ev_of(CMD_MESH_READY, 8'h00, 8'h00, 1'b0, 1'b1));
    repeat (5) add_event(ev_of(CMD_TICK, 8'h00, 8'h00, 1'b0, 1'b1));
    add_event(ev_of(CMD_HEARTBEAT, 8'h00, 8'h00, 1'b0, 1'b1));
    add_event(ev_of(CMD_ONLINE_ACK, 8'hFF, 8'h03, 1'b0, 1'b1));
    // zero reloads fire on the very next tick
    add_write(REG_OFFLINE_TIMEOUT, 20'd0);
    add_write(REG_ANNOUNCE_RETRY, 20'd0);
    add_write(REG_PERIODIC_INTERVAL, 20'd0);
    add_event(ev_of(CMD_MESH_READY, 8'h00, 8'h00, 1'b0, 1'b1));
    add_event(ev_of(CMD_TICK, 8'h00, 8'h00, 1'b0, 1'b1));
    add_event(ev_of(CMD_TICK, 8'h00, 8'h00, 1'b0, 1'b1));

    foreach (plan_q[i]) begin
      if (plan_q[i].is_write) begin
        settle();
        write_reg(plan_q[i].reg_sel, plan_q[i].reg_val);
      end else begin
        push_event(plan_q[i].ev, plan_q[i].pinned, plan_q[i].want);
      end
    end

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        1: load_regs(8'h00, 20'd1, 20'd1, 20'd1);
        2: load_regs(8'hFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        3: load_regs(8'($urandom_range(0, 255)), 20'd0, 20'd0, 20'd0);
        default: load_regs(8'($urandom_range(0, 255)), 20'($urandom_range(1, 24)),
                           20'($urandom_range(1, 10)), 20'($urandom_range(1, 16)));
      endcase
      repeat (140) begin
        if ($urandom_range(0, 39) == 0) quiet = !quiet;
        if ($urandom_range(0, 99) == 0) settle();
        push_event(random_event(), 1'b0, '0);
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (status_q.size() != 0) note_mismatch("expected results never arrived");
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
